// File: hdl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared widths, register indexes and the page table entry type of the
// sliding window working set core.
// ----------------------------------------------------------------------------
package sws_pkg;

   // Sizing of the reference ring and the page table
   localparam int MAX_WINDOW  = 1024;
   localparam int TABLE_DEPTH = 2048;
   localparam int RING_AW     = $clog2(MAX_WINDOW);
   localparam int TBL_AW      = $clog2(TABLE_DEPTH);

   // Field widths
   localparam int ADDR_W  = 64;
   localparam int SIZE_W  = 8;
   localparam int SHIFT_W = 5;
   localparam int WIN_W   = 11;
   localparam int SKIP_W  = 32;
   localparam int WSS_W   = 12;
   localparam int COUNT_W = 11;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_COUNT  = 2'd2;

   // Reset values of the registers
   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST  = 5'd12;
   localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST = 11'd1024;

   // One page table entry
   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  page;
      logic [COUNT_W-1:0] count;
   } tbl_entry_type;

   localparam int TBL_W  = $bits(tbl_entry_type);
   localparam int RING_W = ADDR_W + 1;

endpackage

// File: hdl/sws_if.sv
// ----------------------------------------------------------------------------
// sws_if
// Valid/ready channels of the working set core: reference in, result out,
// and the register write port.
// ----------------------------------------------------------------------------
interface sws_req_if;
   import sws_pkg::*;
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   address;
   logic [SIZE_W-1:0]   access_size;
   modport source (output valid, output address, output access_size, input ready);
   modport sink   (input valid, input address, input access_size, output ready);
endinterface

interface sws_rsp_if;
   import sws_pkg::*;
   logic                valid;
   logic                ready;
   logic [WSS_W-1:0]    working_set_size;
   modport source (output valid, output working_set_size, input ready);
   modport sink   (input valid, input working_set_size, output ready);
endinterface

interface sws_csr_if;
   import sws_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/sws_ram.sv
// ----------------------------------------------------------------------------
// sws_ram
// Simple dual port synchronous RAM, one write and one read port, registered
// read data (old data on a same-address read and write).
// ----------------------------------------------------------------------------
module sws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/sliding_window_working_set_core.sv
// ----------------------------------------------------------------------------
// sliding_window_working_set_core
// Counts the distinct pages touched by the last window_size memory
// references, using a reference ring and a linear probed page table.
//
//  channel   dir  beat
//  req_bus   in   address, access_size
//  rsp_bus   out  working_set_size
//  csr_bus   in   index, data (0 page_shift, 1 window_size, 2 skip_count)
//
// One reference at a time. A skipped beat touches neither ring nor table; a
// counted beat inserts each of its pages into the table by probing, and when a
// result is due the pages of the oldest ring entry are retired by probing and
// backward shifting, all through the single table RAM port pair.
// After reset and after a page_shift or window_size write the table is
// swept clear over all TABLE_DEPTH (2048) slots; no beat is taken meanwhile.
// A result waits in an output register; the core stalls only when a second
// result is due while the first is still held.
// ----------------------------------------------------------------------------
module sliding_window_working_set_core (
   input  logic        clock,
   input  logic        reset,
   sws_req_if.sink     req_bus,
   sws_rsp_if.source   rsp_bus,
   sws_csr_if.sink     csr_bus
);
   import sws_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CALC, ST_PROBE, ST_CHECK, ST_DPROBE, ST_DCHECK,
      ST_TALLY, ST_EMIT, ST_RING, ST_RING_WAIT
   } state_type;

   typedef enum logic [1:0] {STP_ADD1, STP_ADD2, STP_DROP1, STP_DROP2} step_type;

   state_type            state_ff;
   step_type             step_ff;
   logic [SHIFT_W-1:0]   shift_ff;
   logic [WIN_W-1:0]     win_ff;
   logic [SKIP_W-1:0]    skip_ff;
   logic [SKIP_W-1:0]    skipped_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [ADDR_W-1:0]    op_page_ff;
   logic                 two_ff;
   logic [TBL_AW-1:0]    probe_ff;
   logic [TBL_AW-1:0]    hole_ff;
   logic [TBL_AW-1:0]    clr_ff;
   logic [RING_AW-1:0]   pos_ff;
   logic [WIN_W-1:0]     fill_ff;
   logic [WSS_W-1:0]     distinct_ff;
   logic                 rsp_valid_ff;
   logic [WSS_W-1:0]     rsp_data_ff;

   // Memory ports
   logic                 tbl_we;
   logic [TBL_AW-1:0]    tbl_wa;
   tbl_entry_type        tbl_wd;
   logic [TBL_AW-1:0]    tbl_ra;
   logic [TBL_W-1:0]     tbl_rd_raw;
   tbl_entry_type        tbl_rd;
   logic                 ring_we;
   logic [RING_W-1:0]    ring_wd;
   logic [RING_W-1:0]    ring_rd;

   // Derived values
   logic [WIN_W-1:0]     win_eff;
   logic [ADDR_W-1:0]    page_first;
   logic [SIZE_W-1:0]    size_dec;
   logic [ADDR_W-1:0]    last_addr;
   logic                 spans_two;
   logic [WIN_W-1:0]     pos_inc;
   logic [RING_AW-1:0]   pos_in;
   logic [ADDR_W-1:0]    page_inc;
   logic                 is_add;
   logic                 hit;
   logic                 op_fin;
   logic                 new_page;
   logic                 start_del;
   logic                 move_ent;
   logic [TBL_AW-1:0]    dist_home;
   logic [TBL_AW-1:0]    dist_hole;
   logic                 out_free;

   sws_ram #(.WIDTH(TBL_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_wa),
      .wdata (tbl_wd),
      .raddr (tbl_ra),
      .rdata (tbl_rd_raw)
   );

   sws_ram #(.WIDTH(RING_W), .DEPTH(MAX_WINDOW)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (pos_ff),
      .wdata (ring_wd),
      .raddr (pos_ff),
      .rdata (ring_rd)
   );

   assign tbl_rd = tbl_entry_type'(tbl_rd_raw);

   // Window clamp and page span of the held reference
   assign win_eff    = (win_ff == '0) ? WIN_W'(1) :
                       (win_ff > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_ff;
   assign page_first = addr_ff >> shift_ff;
   assign size_dec   = (size_ff == '0) ? '0 : size_ff - SIZE_W'(1);
   assign last_addr  = addr_ff + ADDR_W'(size_dec);
   assign spans_two  = (last_addr < addr_ff) || ((last_addr >> shift_ff) != page_first);
   assign pos_inc    = WIN_W'(pos_ff) + WIN_W'(1);
   assign pos_in     = (pos_inc >= win_eff) ? '0 : pos_inc[RING_AW-1:0];
   assign page_inc   = op_page_ff + ADDR_W'(1);
   assign is_add     = (step_ff == STP_ADD1) || (step_ff == STP_ADD2);
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   assign ring_we = (state_ff == ST_CALC);
   assign ring_wd = {spans_two, page_first};

   // Backward shift delete: an entry moves into the hole unless its home
   // lies cyclically between the hole and its own slot
   assign hit       = tbl_rd.valid && (tbl_rd.page == op_page_ff);
   assign dist_home = probe_ff - tbl_rd.page[TBL_AW-1:0];
   assign dist_hole = probe_ff - hole_ff;
   assign move_ent  = dist_home >= dist_hole;

   // Table access per state
   always_comb begin
      tbl_we    = 1'b0;
      tbl_wa    = probe_ff;
      tbl_wd    = tbl_rd;
      tbl_ra    = probe_ff;
      op_fin    = 1'b0;
      new_page  = 1'b0;
      start_del = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            tbl_we = 1'b1;
            tbl_wa = clr_ff;
            tbl_wd = '0;
         end
         ST_CHECK: begin
            if (is_add) begin
               if (hit) begin
                  tbl_we       = 1'b1;
                  tbl_wd.count = tbl_rd.count + COUNT_W'(1);
                  op_fin       = 1'b1;
               end else if (!tbl_rd.valid) begin
                  tbl_we   = 1'b1;
                  tbl_wd   = '{valid: 1'b1, page: op_page_ff, count: COUNT_W'(1)};
                  op_fin   = 1'b1;
                  new_page = 1'b1;
               end
            end else begin
               if (hit) begin
                  if (tbl_rd.count > COUNT_W'(1)) begin
                     tbl_we       = 1'b1;
                     tbl_wd.count = tbl_rd.count - COUNT_W'(1);
                     op_fin       = 1'b1;
                  end else begin
                     start_del = 1'b1;
                  end
               end else if (!tbl_rd.valid) begin
                  op_fin = 1'b1;
               end
            end
         end
         ST_DCHECK: begin
            tbl_wa = hole_ff;
            // an empty slot, or a scan that came all the way around a full table
            if (!tbl_rd.valid || (probe_ff == hole_ff)) begin
               tbl_we = 1'b1;
               tbl_wd = '0;
               op_fin = 1'b1;
            end else if (move_ent) begin
               tbl_we = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer, registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STP_ADD1;
         shift_ff     <= PAGE_SHIFT_RST;
         win_ff       <= WINDOW_SIZE_RST;
         skip_ff      <= '0;
         skipped_ff   <= '0;
         clr_ff       <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         distinct_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (new_page) begin
            distinct_ff <= distinct_ff + WSS_W'(1);
         end
         if (start_del && (distinct_ff != '0)) begin
            distinct_ff <= distinct_ff - WSS_W'(1);
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + TBL_AW'(1);
               if (clr_ff == TBL_AW'(TABLE_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_bus.valid && req_bus.ready) begin
                  if (skipped_ff < skip_ff) begin
                     skipped_ff <= skipped_ff + SKIP_W'(1);
                  end else begin
                     addr_ff  <= req_bus.address;
                     size_ff  <= req_bus.access_size;
                     state_ff <= ST_CALC;
                  end
               end
            end
            ST_CALC: begin
               pos_ff     <= pos_in;
               op_page_ff <= page_first;
               probe_ff   <= page_first[TBL_AW-1:0];
               two_ff     <= spans_two;
               step_ff    <= STP_ADD1;
               state_ff   <= ST_PROBE;
            end
            ST_PROBE: begin
               state_ff <= ST_CHECK;
            end
            ST_DPROBE: begin
               state_ff <= ST_DCHECK;
            end
            ST_CHECK, ST_DCHECK: begin
               if (op_fin) begin
                  if (((step_ff == STP_ADD1) || (step_ff == STP_DROP1)) && two_ff) begin
                     op_page_ff <= page_inc;
                     probe_ff   <= page_inc[TBL_AW-1:0];
                     step_ff    <= (step_ff == STP_ADD1) ? STP_ADD2 : STP_DROP2;
                     state_ff   <= ST_PROBE;
                  end else if (is_add) begin
                     state_ff <= ST_TALLY;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else if (state_ff == ST_DCHECK) begin
                  if (move_ent) begin
                     hole_ff <= probe_ff;
                  end
                  probe_ff <= probe_ff + TBL_AW'(1);
                  state_ff <= ST_DPROBE;
               end else begin
                  if (start_del) begin
                     hole_ff  <= probe_ff;
                     state_ff <= ST_DPROBE;
                  end else begin
                     state_ff <= ST_PROBE;
                  end
                  probe_ff <= probe_ff + TBL_AW'(1);
               end
            end
            ST_TALLY: begin
               if (fill_ff < win_eff - WIN_W'(1)) begin
                  fill_ff  <= fill_ff + WIN_W'(1);
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= distinct_ff;
                  state_ff     <= ST_RING;
               end
            end
            ST_RING: begin
               state_ff <= ST_RING_WAIT;
            end
            ST_RING_WAIT: begin
               op_page_ff <= ring_rd[ADDR_W-1:0];
               probe_ff   <= ring_rd[TBL_AW-1:0];
               two_ff     <= ring_rd[ADDR_W];
               step_ff    <= STP_DROP1;
               state_ff   <= ST_PROBE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // Register writes are taken only while idle or clearing
         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_bus.index)
               CSR_PAGE_SHIFT, CSR_WINDOW_SIZE: begin
                  if (csr_bus.index == CSR_PAGE_SHIFT) begin
                     shift_ff <= csr_bus.data[SHIFT_W-1:0];
                  end else begin
                     win_ff <= csr_bus.data[WIN_W-1:0];
                  end
                  state_ff    <= ST_CLEAR;
                  clr_ff      <= '0;
                  pos_ff      <= '0;
                  fill_ff     <= '0;
                  distinct_ff <= '0;
               end
               CSR_SKIP_COUNT: begin
                  skip_ff <= csr_bus.data[SKIP_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign req_bus.ready            = (state_ff == ST_IDLE) && !csr_bus.valid;
   assign csr_bus.ready            = (state_ff == ST_IDLE) || (state_ff == ST_CLEAR);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.working_set_size = rsp_data_ff;

endmodule
